@@ hw/rtl/bhpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpc_pkg
// Shared types and constants of the banded heater PWM controller.
// ----------------------------------------------------------------------------
package bhpc_pkg;

   // Period counter width (valid range 8 to 32)
   localparam int COUNT_WIDTH = 16;

   localparam int TEMP_W   = 12;
   localparam int BAND_W   = 12;
   localparam int TICKS_W  = 16;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;

   // Width for the end-of-period compare and the PWM compare
   localparam int END_CMP_W = (COUNT_WIDTH + 1 > TICKS_W + 1) ? COUNT_WIDTH + 1 : TICKS_W + 1;
   localparam int PWM_CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SETPOINT        = 4'd0,
      REG_BAND_HIGH       = 4'd1,
      REG_BAND_MID        = 4'd2,
      REG_BAND_LOW        = 4'd3,
      REG_DUTY_FULL_TICKS = 4'd4,
      REG_DUTY_MID_TICKS  = 4'd5,
      REG_DUTY_LOW_TICKS  = 4'd6,
      REG_PERIOD_TICKS    = 4'd7
   } reg_index_type;

   typedef enum logic {
      CMD_TICK   = 1'b0,
      CMD_SAMPLE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      BAND_OFF  = 2'd0,
      BAND_LOW  = 2'd1,
      BAND_MID  = 2'd2,
      BAND_FULL = 2'd3
   } band_code_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] setpoint;
      logic [BAND_W-1:0]        band_high;
      logic [BAND_W-1:0]        band_mid;
      logic [BAND_W-1:0]        band_low;
      logic [TICKS_W-1:0]       duty_full_ticks;
      logic [TICKS_W-1:0]       duty_mid_ticks;
      logic [TICKS_W-1:0]       duty_low_ticks;
      logic [TICKS_W-1:0]       period_ticks;
   } cfg_type;

   typedef struct packed {
      logic               update;
      band_code_type      band;
      logic [TICKS_W-1:0] duty;
   } band_sel_type;

endpackage

@@ hw/rtl/bhpc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpc_if
// Valid/ready channels of the controller: request, response and CSR write.
// ----------------------------------------------------------------------------
interface bhpc_req_if import bhpc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic signed [TEMP_W-1:0] sample_value;

   modport source (output valid, command, sample_value, input ready);
   modport sink   (input valid, command, sample_value, output ready);
endinterface

interface bhpc_rsp_if import bhpc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               pwm_out;
   logic [1:0]         heat_band;
   logic [TICKS_W-1:0] active_on_ticks;

   modport source (output valid, pwm_out, heat_band, active_on_ticks, input ready);
   modport sink   (input valid, pwm_out, heat_band, active_on_ticks, output ready);
endinterface

interface bhpc_csr_if import bhpc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/bhpc_csr_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpc_csr_regs
// Configuration register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module bhpc_csr_regs import bhpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   bhpc_csr_if.sink csr_bus,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index_type'(csr_bus.index))
            REG_SETPOINT:        cfg_in.setpoint        = signed'(csr_bus.data[TEMP_W-1:0]);
            REG_BAND_HIGH:       cfg_in.band_high       = csr_bus.data[BAND_W-1:0];
            REG_BAND_MID:        cfg_in.band_mid        = csr_bus.data[BAND_W-1:0];
            REG_BAND_LOW:        cfg_in.band_low        = csr_bus.data[BAND_W-1:0];
            REG_DUTY_FULL_TICKS: cfg_in.duty_full_ticks = csr_bus.data[TICKS_W-1:0];
            REG_DUTY_MID_TICKS:  cfg_in.duty_mid_ticks  = csr_bus.data[TICKS_W-1:0];
            REG_DUTY_LOW_TICKS:  cfg_in.duty_low_ticks  = csr_bus.data[TICKS_W-1:0];
            REG_PERIOD_TICKS:    cfg_in.period_ticks    = csr_bus.data[TICKS_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint        <= '0;
         cfg_ff.band_high       <= BAND_W'(192);
         cfg_ff.band_mid        <= BAND_W'(128);
         cfg_ff.band_low        <= BAND_W'(64);
         cfg_ff.duty_full_ticks <= TICKS_W'(1000);
         cfg_ff.duty_mid_ticks  <= TICKS_W'(800);
         cfg_ff.duty_low_ticks  <= TICKS_W'(50);
         cfg_ff.period_ticks    <= TICKS_W'(1000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/bhpc_band_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpc_band_select
// Shortfall against setpoint and heating band decision for one sample.
// ----------------------------------------------------------------------------
module bhpc_band_select import bhpc_pkg::*; (
   input  cfg_type                  cfg,
   input  logic signed [TEMP_W-1:0] sample_value,
   output band_sel_type             sel
);

   logic signed [TEMP_W:0] diff;
   logic [TEMP_W-1:0]      mag;
   logic                   positive;

   // One extra bit so the shortfall never wraps
   assign diff     = {cfg.setpoint[TEMP_W-1], cfg.setpoint}
                   - {sample_value[TEMP_W-1], sample_value};
   assign positive = !diff[TEMP_W] && (diff != '0);
   assign mag      = diff[TEMP_W-1:0];

   always_comb begin
      sel.update = 1'b1;
      sel.band   = BAND_OFF;
      sel.duty   = '0;
      if (!positive) begin
         sel.band = BAND_OFF;
      end else if (mag > cfg.band_high) begin
         sel.band = BAND_FULL;
         sel.duty = cfg.duty_full_ticks;
      end else if (mag > cfg.band_mid) begin
         sel.band = BAND_MID;
         sel.duty = cfg.duty_mid_ticks;
      end else if (mag <= cfg.band_low) begin
         sel.band = BAND_LOW;
         sel.duty = cfg.duty_low_ticks;
      end else begin
         // dead zone between low and mid bands: keep what we had
         sel.update = 1'b0;
      end
   end

endmodule

@@ hw/rtl/banded_heater_pwm_controller.sv @@
`timescale 1ns / 1ps
// The response to an accepted request transaction is registered and offered in the next cycle.
// Throughput: one transaction per cycle while the response sink is ready; the state
//   update and the response are formed in a single pass from the request into the response register.
// Reset (synchronous, active high) clears period count, duties and band,
//   loads the CSR defaults and empties the response register.
// ----------------------------------------------------------------------------
// banded_heater_pwm_controller
// Banded heater controller: samples pick an on-tick count that takes effect
// at the next PWM period boundary; ticks run the period counter.
// ----------------------------------------------------------------------------
module banded_heater_pwm_controller import bhpc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bhpc_req_if.sink   req_bus,
   bhpc_rsp_if.source rsp_bus,
   bhpc_csr_if.sink   csr_bus
);

   cfg_type      cfg;
   band_sel_type sel;

   // Controller state
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [TICKS_W-1:0]     applied_ff, applied_in;
   logic [TICKS_W-1:0]     pending_ff, pending_in;
   band_code_type          band_ff, band_in;

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_pwm_ff, rsp_pwm_in;
   band_code_type      rsp_band_ff, rsp_band_in;
   logic [TICKS_W-1:0] rsp_ticks_ff, rsp_ticks_in;

   logic                 accept;
   logic [COUNT_WIDTH:0] next_count;
   logic                 period_end;

   bhpc_csr_regs u_csr_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   bhpc_band_select u_band_select (
      .cfg          (cfg),
      .sample_value (req_bus.sample_value),
      .sel          (sel)
   );

   // The response register frees up whenever the sink takes its transaction
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // Period end: count reaches period_ticks (any tick if it is zero) or the
   // counter would overflow
   assign next_count = {1'b0, count_ff} + (COUNT_WIDTH+1)'(1);
   assign period_end = (END_CMP_W'(next_count) >= END_CMP_W'(cfg.period_ticks))
                     || next_count[COUNT_WIDTH];

   always_comb begin
      count_in   = count_ff;
      applied_in = applied_ff;
      pending_in = pending_ff;
      band_in    = band_ff;
      if (accept) begin
         if (command_type'(req_bus.command) == CMD_TICK) begin
            if (period_end) begin
               count_in   = '0;
               applied_in = pending_ff;
            end else begin
               count_in = next_count[COUNT_WIDTH-1:0];
            end
         end else if (sel.update) begin
            pending_in = sel.duty;
            band_in    = sel.band;
         end
      end
   end

   // Response reflects the state after this transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pwm_in   = rsp_pwm_ff;
      rsp_band_in  = rsp_band_ff;
      rsp_ticks_in = rsp_ticks_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_pwm_in   = PWM_CMP_W'(count_in) < PWM_CMP_W'(applied_in);
         rsp_band_in  = band_in;
         rsp_ticks_in = applied_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         applied_ff   <= '0;
         pending_ff   <= '0;
         band_ff      <= BAND_OFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         applied_ff   <= applied_in;
         pending_ff   <= pending_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      rsp_pwm_ff   <= rsp_pwm_in;
      rsp_band_ff  <= rsp_band_in;
      rsp_ticks_ff <= rsp_ticks_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.pwm_out         = rsp_pwm_ff;
   assign rsp_bus.heat_band       = rsp_band_ff;
   assign rsp_bus.active_on_ticks = rsp_ticks_ff;

endmodule
